[rtl/ltc_pkg.sv]
`default_nettype none

package ltc_pkg;

	localparam int DATA_W = 64;
	localparam int CNT_W  = 63;
	localparam int NCELL  = CNT_W;

	localparam logic [2:0] KIND_LT = 3'd0;
	localparam logic [2:0] KIND_LE = 3'd1;
	localparam logic [2:0] KIND_GT = 3'd2;
	localparam logic [2:0] KIND_GE = 3'd3;
	localparam logic [2:0] KIND_NE = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_OVF     = 2'd1;
	localparam logic [1:0] ST_NOLAND  = 2'd2;
	localparam logic [1:0] ST_BADSTEP = 2'd3;

	localparam logic [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic        [2:0]        kind;
		logic signed [DATA_W-1:0] start_req;
		logic signed [DATA_W-1:0] bound;
		logic signed [DATA_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [CNT_W-1:0] trip_count;
	} res_t;

	// one divider stage: remaining dividend bits, partial remainder, quotient so far
	typedef struct packed {
		logic [1:0]        status;
		logic              exact;
		logic [CNT_W-1:0]  num;
		logic [CNT_W-1:0]  rem;
		logic [CNT_W-1:0]  quo;
		logic [DATA_W-1:0] dvsr;
	} div_t;

endpackage

`default_nettype wire

[rtl/ltc_front.sv]
`default_nettype none

module ltc_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cmd_valid,
	input  wire ltc_pkg::cmd_t cmd,
	input  wire logic         hold_dn,
	output logic              hold,
	output logic              valid_q,
	output ltc_pkg::div_t     beat_q
);

	localparam int W = ltc_pkg::DATA_W;

	logic              neg;
	logic [W-1:0]      s_w;
	logic [W-1:0]      b_w;
	logic [W-1:0]      t_w;
	logic [W-1:0]      mag;
	logic              inc_l;
	logic              inc_g;
	logic [W:0]        dbs;
	logic [W:0]        dsb;
	logic              dbs_pos;
	logic              dsb_pos;
	logic              dbs_big;
	logic              dsb_big;
	ltc_pkg::div_t     nxt;

	assign s_w   = cmd.start_req;
	assign b_w   = cmd.bound;
	assign t_w   = cmd.step;
	assign neg   = t_w[W-1];
	assign mag   = neg ? (~t_w + W'(1)) : t_w;
	assign inc_l = (cmd.kind == ltc_pkg::KIND_LE);
	assign inc_g = (cmd.kind == ltc_pkg::KIND_GE);
	assign dbs   = {b_w[W-1], b_w} - {s_w[W-1], s_w} + (W+1)'(inc_l);
	assign dsb   = {s_w[W-1], s_w} - {b_w[W-1], b_w} + (W+1)'(inc_g);

	assign dbs_pos = !dbs[W] && (dbs[W-1:0] != '0);
	assign dsb_pos = !dsb[W] && (dsb[W-1:0] != '0);
	assign dbs_big = !dbs[W] && dbs[W-1];
	assign dsb_big = !dsb[W] && dsb[W-1];

	always_comb begin
		nxt        = '0;
		nxt.status = ltc_pkg::ST_OK;
		nxt.dvsr   = mag;
		if (t_w == '0) begin
			nxt.status = ltc_pkg::ST_BADSTEP;
		end else begin
			unique case (cmd.kind) inside
				ltc_pkg::KIND_LT, ltc_pkg::KIND_LE: begin
					if (neg)
						nxt.status = ltc_pkg::ST_BADSTEP;
					else if (inc_l && b_w == ltc_pkg::S_MAX)
						nxt.status = ltc_pkg::ST_OVF;
					else if (dbs_pos && dbs_big)
						nxt.status = ltc_pkg::ST_OVF;
					else if (dbs_pos)
						nxt.num = dbs[ltc_pkg::CNT_W-1:0];
				end
				ltc_pkg::KIND_GT, ltc_pkg::KIND_GE: begin
					if (!neg)
						nxt.status = ltc_pkg::ST_BADSTEP;
					else if (inc_g && b_w == ltc_pkg::S_MIN)
						nxt.status = ltc_pkg::ST_OVF;
					else if (dsb_pos && dsb_big)
						nxt.status = ltc_pkg::ST_OVF;
					else if (dsb_pos)
						nxt.num = dsb[ltc_pkg::CNT_W-1:0];
				end
				ltc_pkg::KIND_NE: begin
					nxt.exact = 1'b1;
					if (dbs_pos) begin
						if (neg)
							nxt.status = ltc_pkg::ST_NOLAND;
						else if (dbs_big)
							nxt.status = ltc_pkg::ST_OVF;
						else
							nxt.num = dbs[ltc_pkg::CNT_W-1:0];
					end else if (dsb_pos) begin
						if (!neg)
							nxt.status = ltc_pkg::ST_NOLAND;
						else if (dsb_big)
							nxt.status = ltc_pkg::ST_OVF;
						else
							nxt.num = dsb[ltc_pkg::CNT_W-1:0];
					end
				end
				default: begin
					nxt.status = ltc_pkg::ST_BADSTEP;
				end
			endcase
		end
	end

	assign hold = valid_q && hold_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!hold) begin
			valid_q <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold && cmd_valid) begin
			beat_q <= nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/ltc_cell.sv]
`default_nettype none

module ltc_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          valid_up,
	input  wire ltc_pkg::div_t beat_up,
	input  wire logic          hold_dn,
	output logic               hold,
	output logic               valid_q,
	output ltc_pkg::div_t      beat_q
);

	localparam int W = ltc_pkg::DATA_W;
	localparam int C = ltc_pkg::CNT_W;

	logic [W-1:0]  r_sh;
	logic [W-1:0]  diff;
	logic          ge;
	ltc_pkg::div_t nxt;

	assign r_sh = {beat_up.rem, beat_up.num[C-1]};
	assign diff = r_sh - beat_up.dvsr;
	assign ge   = (r_sh >= beat_up.dvsr);

	always_comb begin
		nxt     = beat_up;
		nxt.num = {beat_up.num[C-2:0], 1'b0};
		nxt.rem = ge ? diff[C-1:0] : r_sh[C-1:0];
		nxt.quo = {beat_up.quo[C-2:0], ge};
	end

	assign hold = valid_q && hold_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!hold) begin
			valid_q <= valid_up;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold && valid_up) begin
			beat_q <= nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/loop_trip_count_core.sv]
// channel | dir | handshake             | beat
// cmd     | in  | cmd_valid / cmd_stall | ltc_pkg::cmd_t: kind, start_req, bound, step
// res     | out | res_valid / res_stall | ltc_pkg::res_t: status, trip_count
//
// One beat in per cycle, one result out per cycle while res is not stalled;
// path: span/step stage, 63 one-bit restoring divide cells, result register.
// arst_n clears only the stage valid bits.
// A stall on res halts only occupied stages; empty slots ahead still fill,
// so cmd_stall rises once the chain is full back to the span/step stage.
`default_nettype none

module loop_trip_count_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire ltc_pkg::cmd_t cmd,
	output logic               res_valid,
	input  wire logic          res_stall,
	output ltc_pkg::res_t      res
);

	localparam int N = ltc_pkg::NCELL;
	localparam int C = ltc_pkg::CNT_W;

	logic          cell_valid [N+1];
	ltc_pkg::div_t cell_beat  [N+1];
	logic          cell_hold  [N+2];
	logic          res_valid_q;
	ltc_pkg::res_t res_q;
	ltc_pkg::div_t last;
	logic [C-1:0]  cnt;
	ltc_pkg::res_t res_nxt;

	ltc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.hold_dn  (cell_hold[1]),
		.hold     (cell_hold[0]),
		.valid_q  (cell_valid[0]),
		.beat_q   (cell_beat[0])
	);

	for (genvar i = 1; i <= N; i++) begin : g_cell
		ltc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_up(cell_valid[i-1]),
			.beat_up (cell_beat[i-1]),
			.hold_dn (cell_hold[i+1]),
			.hold    (cell_hold[i]),
			.valid_q (cell_valid[i]),
			.beat_q  (cell_beat[i])
		);
	end

	assign cell_hold[N+1] = res_valid_q && res_stall;
	assign cmd_stall      = cell_hold[0];

	assign last = cell_beat[N];

	always_comb begin
		res_nxt        = '0;
		res_nxt.status = last.status;
		if (last.exact)
			cnt = last.quo;
		else
			cnt = last.quo + C'(last.rem != '0);
		if (last.status == ltc_pkg::ST_OK) begin
			if (last.exact && last.rem != '0)
				res_nxt.status = ltc_pkg::ST_NOLAND;
			else
				res_nxt.trip_count = cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!cell_hold[N+1]) begin
			res_valid_q <= cell_valid[N];
		end
	end

	always_ff @(posedge clk) begin
		if (!cell_hold[N+1] && cell_valid[N]) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_res_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != ltc_pkg::ST_OK |-> res.trip_count == '0)
		else $error("trip_count nonzero on failed status");

	a_stall_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> cell_valid[0] && cell_valid[N] && res_valid_q)
		else $error("input stalled with a free stage");

	a_front_dvsr: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[0] && cell_beat[0].status == ltc_pkg::ST_OK |->
			cell_beat[0].dvsr != '0)
		else $error("zero divisor entered the divide chain");

	a_res_advance: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid[N] && !(res_valid && res_stall) |=> res_valid)
		else $error("finished beat lost at result register");

endmodule

`default_nettype wire
